### hw/rtl/skhm_pkg.sv
`timescale 1ns / 1ps
package skhm_pkg;

    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 8;
    localparam int DEF_MAX_ENTRIES = 1024;

    localparam int DW        = 16;
    localparam int PTR_W     = 11;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        OP_LD_PTR,
        OP_LD_VAL,
        OP_LD_X,
        OP_LD_Y,
        OP_START,
        OP_RD_Y
    } t_op;

    typedef enum logic [2:0] {
        CFG_ALPHA_RE,
        CFG_ALPHA_IM,
        CFG_BETA_RE,
        CFG_BETA_IM,
        CFG_ROW_CNT,
        CFG_COL_CNT
    } t_cfg;

    typedef enum logic [1:0] {
        M_SCALE,
        M_MVC,
        M_MVV
    } t_mode;

    typedef enum logic [2:0] {
        K_SCALE,
        K_VC,
        K_VV,
        K_MVC,
        K_MVV
    } t_kern;

    typedef enum logic [2:0] {
        A_ALRE,
        A_ALIM,
        A_BERE,
        A_BEIM,
        A_KRE,
        A_KIM
    } t_asel;

    typedef enum logic [2:0] {
        B_YRE,
        B_YIM,
        B_XRE,
        B_XIM,
        B_VRE,
        B_VIM
    } t_bsel;

    typedef struct packed {
        t_asel asel;
        t_bsel bsel;
        logic  neg;
        logic  first;
        logic  last;
        logic  part;
        logic  inity;
    } t_term;

    typedef struct packed {
        logic  row_clr;
        logic  row_inc;
        logic  col_clr;
        logic  col_inc;
        logic  ptr_hi;
        logic  ptr_lo_lat;
        logic  ptr_hi_lat;
        logic  ent_inc;
        logic  a_lat;
        logic  v_lat;
        logic  xy_lat;
        logic  kern_start;
        t_kern kern;
        logic  lat_vc;
        logic  lat_vv;
        logic  y_we;
        t_mode mode;
        logic  host_rd;
        logic  out_load;
        logic  out_kind;
    } t_cmd;

    typedef struct packed {
        logic row_end;
        logic col_end;
        logic ent_end;
        logic ent_skip;
        logic kern_busy;
        logic out_free;
    } t_stat;

    function automatic t_term mk_term(t_asel a, t_bsel b, logic neg, logic first,
                                      logic last, logic part, logic inity);
        t_term t;
        t.asel  = a;
        t.bsel  = b;
        t.neg   = neg;
        t.first = first;
        t.last  = last;
        t.part  = part;
        t.inity = inity;
        return t;
    endfunction

    function automatic logic [3:0] f_len(t_kern k);
        return (k == K_SCALE) ? 4'd8 : 4'd4;
    endfunction

    // Product terms of each kernel; the real part comes first, then the imaginary part.
    function automatic t_term f_term(t_kern k, logic [2:0] s);
        t_term t;
        t = mk_term(A_ALRE, B_XRE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        unique case (k)
            K_SCALE: begin
                unique case (s)
                    3'd0: t = mk_term(A_BERE, B_YRE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
                    3'd1: t = mk_term(A_BEIM, B_YIM, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                    3'd2: t = mk_term(A_ALRE, B_XRE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                    3'd3: t = mk_term(A_ALIM, B_XIM, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
                    3'd4: t = mk_term(A_BERE, B_YIM, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
                    3'd5: t = mk_term(A_BEIM, B_YRE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
                    3'd6: t = mk_term(A_ALRE, B_XIM, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
                    default: t = mk_term(A_ALIM, B_XRE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
                endcase
            end
            K_VC: begin
                unique case (s[1:0])
                    2'd0: t = mk_term(A_ALRE, B_VRE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
                    2'd1: t = mk_term(A_ALIM, B_VIM, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
                    2'd2: t = mk_term(A_ALRE, B_VIM, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
                    default: t = mk_term(A_ALIM, B_VRE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
                endcase
            end
            K_VV: begin
                unique case (s[1:0])
                    2'd0: t = mk_term(A_ALRE, B_VRE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
                    2'd1: t = mk_term(A_ALIM, B_VIM, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
                    2'd2: t = mk_term(A_ALRE, B_VIM, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
                    default: t = mk_term(A_ALIM, B_VRE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
                endcase
            end
            default: begin
                unique case (s[1:0])
                    2'd0: t = mk_term(A_KRE, B_XRE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
                    2'd1: t = mk_term(A_KIM, B_XIM, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
                    2'd2: t = mk_term(A_KRE, B_XIM, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
                    default: t = mk_term(A_KIM, B_XRE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
                endcase
            end
        endcase
        return t;
    endfunction

endpackage

### hw/rtl/skhm_in_if.sv
`timescale 1ns / 1ps
interface skhm_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [9:0]         entry_index;
    logic [6:0]         row_index;
    logic [2:0]         col_index;
    logic [10:0]        pointer_value;
    logic signed [15:0] data_real;
    logic signed [15:0] data_imag;

    modport source (
        output valid, opcode, entry_index, row_index, col_index, pointer_value,
               data_real, data_imag,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, row_index, col_index, pointer_value,
               data_real, data_imag,
        output ready
    );
endinterface

### hw/rtl/skhm_out_if.sv
`timescale 1ns / 1ps
interface skhm_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [15:0] y_real;
    logic signed [15:0] y_imag;

    modport source (output valid, result_kind, y_real, y_imag, input ready);
    modport sink (input valid, result_kind, y_real, y_imag, output ready);
endinterface

### hw/rtl/skhm_ram.sv
`timescale 1ns / 1ps
module skhm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/skhm_dp.sv
`timescale 1ns / 1ps
module skhm_dp import skhm_pkg::*; #(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DW-1:0]        i_cfg_data,
    input  logic                 i_in_acc,
    input  logic [2:0]           i_opcode,
    input  logic [9:0]           i_entry_index,
    input  logic [6:0]           i_row_index,
    input  logic [2:0]           i_col_index,
    input  logic [PTR_W-1:0]     i_pointer_value,
    input  logic signed [DW-1:0] i_data_real,
    input  logic signed [DW-1:0] i_data_imag,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_result_kind,
    output logic signed [DW-1:0] o_y_real,
    output logic signed [DW-1:0] o_y_imag
);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int XYD = MAX_ROWS * MAX_COLS;
    localparam int AW  = $clog2(XYD);
    localparam int VAW = $clog2(MAX_ENTRIES);

    function automatic logic signed [DW-1:0] rnd_sat(logic signed [35:0] v);
        logic signed [36:0] s;
        logic signed [25:0] q;
        s = {v[35], v} + 37'sd1024;
        q = s[36:11];
        if (q > 26'sd32767) begin
            return 16'sh7fff;
        end else if (q < -26'sd32768) begin
            return 16'sh8000;
        end
        return q[15:0];
    endfunction

    logic signed [DW-1:0] r_al_re, r_al_im, r_be_re, r_be_im;
    logic [6:0]           r_row_cnt;
    logic [3:0]           r_col_cnt;

    logic [RW-1:0]    r_row, r_arow;
    logic [CW-1:0]    r_col;
    logic [PTR_W-1:0] r_ai, r_end;
    logic [AW-1:0]    r_haddr;
    logic             r_hok;

    logic signed [DW-1:0] r_y_re, r_y_im, r_x_re, r_x_im, r_v_re, r_v_im;
    logic signed [DW-1:0] r_vc_re, r_vc_im, r_vv_re, r_vv_im, r_res_re, r_res_im;

    t_kern                r_kern;
    logic                 r_run;
    logic [3:0]           r_step;
    logic signed [31:0]   r_prod;
    t_term                r_t1;
    logic                 r_v1;
    logic signed [35:0]   r_acc;
    logic                 r_v2;
    logic                 r_p2;

    t_op               w_op;
    logic              w_hok;
    logic [AW-1:0]     w_haddr;
    logic [RW-1:0]     w_yrow, w_xrow;
    logic [AW-1:0]     w_yaddr, w_xaddr;
    logic [2*DW-1:0]   w_y_rd, w_x_rd, w_v_rd;
    logic [PTR_W-1:0]  w_rs_rd;
    logic              w_y_we;
    logic [AW-1:0]     w_y_waddr;
    logic [2*DW-1:0]   w_y_wdata;
    logic [RW-1:0]     w_rs_raddr;
    t_term             w_term;
    logic              w_issue;
    logic signed [DW-1:0] w_a, w_b, w_k_re, w_k_im;
    logic signed [35:0] w_base, w_prod_ext, n_acc;

    assign w_op    = t_op'(i_opcode);
    assign w_hok   = (int'(i_row_index) < MAX_ROWS) && (int'(i_col_index) < MAX_COLS);
    assign w_haddr = AW'(int'(i_row_index) * MAX_COLS + int'(i_col_index));

    assign w_yrow  = (i_cmd.mode == M_MVV) ? r_arow : r_row;
    assign w_xrow  = (i_cmd.mode == M_MVC) ? r_arow : r_row;
    assign w_yaddr = AW'(int'(w_yrow) * MAX_COLS + int'(r_col));
    assign w_xaddr = AW'(int'(w_xrow) * MAX_COLS + int'(r_col));

    assign w_y_we    = (i_in_acc && w_op == OP_LD_Y && w_hok) || i_cmd.y_we;
    assign w_y_waddr = i_cmd.y_we ? w_yaddr : w_haddr;
    assign w_y_wdata = i_cmd.y_we ? {r_res_re, r_res_im} : {i_data_real, i_data_imag};

    assign w_rs_raddr = i_cmd.ptr_hi ? RW'(int'(r_row) + 1) : r_row;

    skhm_ram #(.WIDTH(2 * DW), .DEPTH(XYD)) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (w_y_we),
        .i_waddr (w_y_waddr),
        .i_wdata (w_y_wdata),
        .i_raddr (i_cmd.host_rd ? r_haddr : w_yaddr),
        .o_rdata (w_y_rd)
    );

    skhm_ram #(.WIDTH(2 * DW), .DEPTH(XYD)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (i_in_acc && w_op == OP_LD_X && w_hok),
        .i_waddr (w_haddr),
        .i_wdata ({i_data_real, i_data_imag}),
        .i_raddr (w_xaddr),
        .o_rdata (w_x_rd)
    );

    skhm_ram #(.WIDTH(2 * DW), .DEPTH(MAX_ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (i_in_acc && w_op == OP_LD_VAL && int'(i_entry_index) < MAX_ENTRIES),
        .i_waddr (VAW'(i_entry_index)),
        .i_wdata ({i_data_real, i_data_imag}),
        .i_raddr (VAW'(r_ai)),
        .o_rdata (w_v_rd)
    );

    skhm_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ROWS + 1)) u_rs_ram (
        .i_clk   (i_clk),
        .i_we    (i_in_acc && w_op == OP_LD_PTR && int'(i_row_index) <= MAX_ROWS),
        .i_waddr (RW'(i_row_index)),
        .i_wdata (i_pointer_value),
        .i_raddr (w_rs_raddr),
        .o_rdata (w_rs_rd)
    );

    assign o_stat.row_end  = (int'(r_row) >= int'(r_row_cnt)) || (int'(r_row) >= MAX_ROWS);
    assign o_stat.col_end  = (int'(r_col) >= int'(r_col_cnt)) || (int'(r_col) >= MAX_COLS);
    assign o_stat.ent_end  = r_ai >= r_end;
    assign o_stat.ent_skip = (int'(r_ai) >= MAX_ENTRIES)
                          || (int'(r_row) + 1 + int'(r_ai) < int'(r_end))
                          || (int'(r_ai) + 1 >= int'(r_end));
    assign o_stat.kern_busy = r_run;
    assign o_stat.out_free  = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_al_re      <= 16'sd2048;
            r_al_im      <= '0;
            r_be_re      <= '0;
            r_be_im      <= '0;
            r_row_cnt    <= 7'd64;
            r_col_cnt    <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (t_cfg'(i_cfg_idx))
                CFG_ALPHA_RE: r_al_re   <= i_cfg_data;
                CFG_ALPHA_IM: r_al_im   <= i_cfg_data;
                CFG_BETA_RE:  r_be_re   <= i_cfg_data;
                CFG_BETA_IM:  r_be_im   <= i_cfg_data;
                CFG_ROW_CNT:  r_row_cnt <= i_cfg_data[6:0];
                CFG_COL_CNT:  r_col_cnt <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_clr) begin
            r_row <= '0;
        end else if (i_cmd.row_inc) begin
            r_row <= r_row + 1'b1;
        end
        if (i_cmd.col_clr) begin
            r_col <= '0;
        end else if (i_cmd.col_inc) begin
            r_col <= r_col + 1'b1;
        end
        if (i_cmd.ptr_lo_lat) begin
            r_ai <= w_rs_rd;
        end else if (i_cmd.ent_inc) begin
            r_ai <= r_ai + 1'b1;
        end
        if (i_cmd.ptr_hi_lat) begin
            r_end <= w_rs_rd;
        end
        if (i_cmd.a_lat) begin
            r_arow <= RW'(int'(r_row) + 1 + int'(r_ai) - int'(r_end));
        end
        if (i_in_acc && w_op == OP_RD_Y) begin
            r_haddr <= w_haddr;
            r_hok   <= w_hok;
        end
        if (i_cmd.xy_lat) begin
            {r_y_re, r_y_im} <= w_y_rd;
            {r_x_re, r_x_im} <= w_x_rd;
        end
        if (i_cmd.v_lat) begin
            {r_v_re, r_v_im} <= w_v_rd;
        end
        if (i_cmd.lat_vc) begin
            r_vc_re <= r_res_re;
            r_vc_im <= r_res_im;
        end
        if (i_cmd.lat_vv) begin
            r_vv_re <= r_res_re;
            r_vv_im <= r_res_im;
        end
    end

    assign w_issue = r_run && (r_step < f_len(r_kern));
    assign w_term  = f_term(r_kern, r_step[2:0]);
    assign w_k_re  = (r_kern == K_MVV) ? r_vv_re : r_vc_re;
    assign w_k_im  = (r_kern == K_MVV) ? r_vv_im : r_vc_im;

    always_comb begin
        unique case (w_term.asel)
            A_ALRE:  w_a = r_al_re;
            A_ALIM:  w_a = r_al_im;
            A_BERE:  w_a = r_be_re;
            A_BEIM:  w_a = r_be_im;
            A_KRE:   w_a = w_k_re;
            default: w_a = w_k_im;
        endcase
        unique case (w_term.bsel)
            B_YRE:   w_b = r_y_re;
            B_YIM:   w_b = r_y_im;
            B_XRE:   w_b = r_x_re;
            B_XIM:   w_b = r_x_im;
            B_VRE:   w_b = r_v_re;
            default: w_b = r_v_im;
        endcase
    end

    always_comb begin
        logic signed [DW-1:0] yp;
        yp = r_t1.part ? r_y_im : r_y_re;
        if (r_t1.first) begin
            w_base = r_t1.inity ? {{9{yp[DW-1]}}, yp, 11'b0} : '0;
        end else begin
            w_base = r_acc;
        end
        w_prod_ext = {{4{r_prod[31]}}, r_prod};
        n_acc = r_t1.neg ? (w_base - w_prod_ext) : (w_base + w_prod_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= '0;
            r_kern <= K_SCALE;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            if (i_cmd.kern_start) begin
                r_kern <= i_cmd.kern;
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                if (r_step == f_len(r_kern) + 4'd1) begin
                    r_run <= 1'b0;
                end
                r_step <= r_step + 1'b1;
            end
            r_v1 <= w_issue;
            r_v2 <= r_v1 && r_t1.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        r_t1   <= w_term;
        if (r_v1) begin
            r_acc <= n_acc;
        end
        r_p2 <= r_t1.part;
        if (r_v2) begin
            if (r_p2) begin
                r_res_im <= rnd_sat(r_acc);
            end else begin
                r_res_re <= rnd_sat(r_acc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_result_kind <= i_cmd.out_kind;
            if (i_cmd.out_kind && r_hok) begin
                {o_y_real, o_y_imag} <= w_y_rd;
            end else begin
                o_y_real <= '0;
                o_y_imag <= '0;
            end
        end
    end
endmodule

### hw/rtl/skhm_ctrl.sv
`timescale 1ns / 1ps
module skhm_ctrl import skhm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_opcode,
    input  t_stat      i_stat,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_WAIT,
        S_RD_OUT,
        S_ROW_CHK,
        S_CL_RD,
        S_CL_LAT,
        S_CL_MUL,
        S_CL_WR,
        S_PTR_A,
        S_PTR_B,
        S_PTR_C,
        S_ENT_CHK,
        S_ENT_LAT,
        S_K_VC,
        S_K_VV,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd      = '0;
        o_cmd.mode = r_mode;
        o_cmd.kern = K_SCALE;
        n_state    = r_state;
        n_mode     = r_mode;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (t_op'(i_opcode))
                        OP_START: begin
                            o_cmd.row_clr = 1'b1;
                            n_state = S_ROW_CHK;
                        end
                        OP_RD_Y: n_state = S_RD_WAIT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD_WAIT: begin
                o_cmd.host_rd = 1'b1;
                n_state = S_RD_OUT;
            end
            S_RD_OUT: begin
                o_cmd.host_rd = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ROW_CHK: begin
                if (i_stat.row_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.col_clr = 1'b1;
                    n_mode  = M_SCALE;
                    n_state = S_CL_RD;
                end
            end
            S_CL_RD: begin
                if (i_stat.col_end) begin
                    unique case (r_mode)
                        M_SCALE: n_state = S_PTR_A;
                        M_MVC: begin
                            o_cmd.col_clr = 1'b1;
                            n_mode  = M_MVV;
                            n_state = S_CL_RD;
                        end
                        default: begin
                            o_cmd.ent_inc = 1'b1;
                            n_state = S_ENT_CHK;
                        end
                    endcase
                end else begin
                    n_state = S_CL_LAT;
                end
            end
            S_CL_LAT: begin
                o_cmd.xy_lat     = 1'b1;
                o_cmd.kern_start = 1'b1;
                unique case (r_mode)
                    M_SCALE: o_cmd.kern = K_SCALE;
                    M_MVC:   o_cmd.kern = K_MVC;
                    default: o_cmd.kern = K_MVV;
                endcase
                n_state = S_CL_MUL;
            end
            S_CL_MUL: begin
                if (!i_stat.kern_busy) begin
                    n_state = S_CL_WR;
                end
            end
            S_CL_WR: begin
                o_cmd.y_we    = 1'b1;
                o_cmd.col_inc = 1'b1;
                n_state = S_CL_RD;
            end
            S_PTR_A: n_state = S_PTR_B;
            S_PTR_B: begin
                o_cmd.ptr_hi     = 1'b1;
                o_cmd.ptr_lo_lat = 1'b1;
                n_state = S_PTR_C;
            end
            S_PTR_C: begin
                o_cmd.ptr_hi_lat = 1'b1;
                n_state = S_ENT_CHK;
            end
            S_ENT_CHK: begin
                if (i_stat.ent_end) begin
                    o_cmd.row_inc = 1'b1;
                    n_state = S_ROW_CHK;
                end else if (i_stat.ent_skip) begin
                    o_cmd.ent_inc = 1'b1;
                end else begin
                    o_cmd.a_lat = 1'b1;
                    n_state = S_ENT_LAT;
                end
            end
            S_ENT_LAT: begin
                o_cmd.v_lat      = 1'b1;
                o_cmd.kern_start = 1'b1;
                o_cmd.kern       = K_VC;
                n_state = S_K_VC;
            end
            S_K_VC: begin
                if (!i_stat.kern_busy) begin
                    o_cmd.lat_vc     = 1'b1;
                    o_cmd.kern_start = 1'b1;
                    o_cmd.kern       = K_VV;
                    n_state = S_K_VV;
                end
            end
            S_K_VV: begin
                if (!i_stat.kern_busy) begin
                    o_cmd.lat_vv  = 1'b1;
                    o_cmd.col_clr = 1'b1;
                    n_mode  = M_MVC;
                    n_state = S_CL_RD;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_SCALE;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end
endmodule

### hw/rtl/skyline_hermitian_matmul_transposed.sv
`timescale 1ns / 1ps
// Computes Y = alpha*A*X + beta*Y for a Hermitian matrix A with a unit diagonal whose strictly
// lower part is stored in skyline form, in complex Q4.11 with saturation. Load transactions
// (row starts, values, X and Y) may come back to back. A Y read passes through a wait state
// for the registered RAM read. A start transaction holds the input for the whole run, which
// steps one real 16x16 multiply per cycle through a multiply-accumulate pipeline while a
// kernel runs: each row gets one scaling pass over its columns, each stored off-diagonal
// entry gets two passes over the columns, and each skipped slot is stepped over; a finish
// transaction follows.
module skyline_hermitian_matmul_transposed import skhm_pkg::*; #(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    skhm_in_if.sink              i_in,
    skhm_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DW-1:0]        i_cfg_data
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;
    logic  w_in_acc;

    assign i_in.ready = w_in_ready;
    assign w_in_acc   = i_in.valid && w_in_ready;

    skhm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (i_in.opcode),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    skhm_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_acc        (w_in_acc),
        .i_opcode        (i_in.opcode),
        .i_entry_index   (i_in.entry_index),
        .i_row_index     (i_in.row_index),
        .i_col_index     (i_in.col_index),
        .i_pointer_value (i_in.pointer_value),
        .i_data_real     (i_in.data_real),
        .i_data_imag     (i_in.data_imag),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_result_kind   (o_out.result_kind),
        .o_y_real        (o_out.y_real),
        .o_y_imag        (o_out.y_imag)
    );

    a_start_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in.opcode == OP_START |=> !w_in_ready)
        else $error("input still ready after a start transaction");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.kern_busy |-> !w_in_ready)
        else $error("input ready while the multiplier is busy");

    a_finish_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.result_kind |-> o_out.y_real == 0 && o_out.y_imag == 0)
        else $error("finish transaction carries nonzero data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.y_real))
        else $error("output transaction dropped or changed while stalled");
endmodule
